[rtl/gha_pkg.sv]
// ============================================================================
// Generational handle allocator package
// Shared sizes, operation codes and the structures passed between modules.
// ============================================================================
package gha_pkg;

  // Number of handle slots. Must be a power of two.
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  // Wide enough to hold a slot count up to and including CAPACITY.
  localparam int unsigned SLOT_W   = $clog2(CAPACITY + 1);

  localparam int unsigned OP_W   = 2;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned KIND_W = 32;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RECLAIM = 2'd2,
    OP_LOOKUP  = 2'd3
  } gha_op_e;

  // Write controls for the slot table.
  typedef struct packed {
    logic              id_we;
    logic              kind_we;
    logic [IDX_W-1:0]  addr;
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
  } gha_wr_t;

  // Classification of one slot and the ids derived from it.
  typedef struct packed {
    logic            is_free;
    logic            is_marked;
    logic            id_match;
    logic [ID_W-1:0] stamped;
    logic [ID_W-1:0] former;
    logic [ID_W-1:0] cleared;
    logic [ID_W-1:0] released;
  } gha_eval_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [ID_W-1:0]   handle_out;
    logic [KIND_W-1:0] kind_out;
    logic              success;
    logic [CNT_W-1:0]  reclaimed_count;
    logic [CNT_W-1:0]  active_count;
    logic [CNT_W-1:0]  high_water;
    logic              last;
  } gha_rsp_t;

endpackage

[rtl/gha_if.sv]
// ============================================================================
// Generational handle allocator channels
// Request and response channels with a valid/ready handshake.
// ============================================================================
interface gha_req_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::OP_W-1:0]    operation;
  logic [gha_pkg::ID_W-1:0]    entity_id;
  logic [gha_pkg::KIND_W-1:0]  kind_tag;

  modport source (output valid, output operation, output entity_id, output kind_tag,
                  input ready);
  modport sink   (input valid, input operation, input entity_id, input kind_tag,
                  output ready);
endinterface

interface gha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::ID_W-1:0]    handle_out;
  logic [gha_pkg::KIND_W-1:0]  kind_out;
  logic                        success;
  logic [gha_pkg::CNT_W-1:0]   reclaimed_count;
  logic [gha_pkg::CNT_W-1:0]   active_count;
  logic [gha_pkg::CNT_W-1:0]   high_water;
  logic                        last;

  modport source (output valid, output handle_out, output kind_out, output success,
                  output reclaimed_count, output active_count, output high_water,
                  output last, input ready);
  modport sink   (input valid, input handle_out, input kind_out, input success,
                  input reclaimed_count, input active_count, input high_water,
                  input last, output ready);
endinterface

[rtl/gha_slot_store.sv]
// ============================================================================
// Slot table storage
// Id and kind memories with one write port and one registered read port.
// ============================================================================
module gha_slot_store (
  input  logic                          clk_i,
  input  logic [gha_pkg::IDX_W-1:0]     rd_addr_i,
  input  gha_pkg::gha_wr_t              wr_i,
  output logic [gha_pkg::ID_W-1:0]      rd_id_o,
  output logic [gha_pkg::KIND_W-1:0]    rd_kind_o
);

  logic [gha_pkg::ID_W-1:0]   id_mem   [gha_pkg::CAPACITY];
  logic [gha_pkg::KIND_W-1:0] kind_mem [gha_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (wr_i.id_we) begin
      id_mem[wr_i.addr] <= wr_i.id;
    end
    rd_id_o <= id_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.kind_we) begin
      kind_mem[wr_i.addr] <= wr_i.kind;
    end
    rd_kind_o <= kind_mem[rd_addr_i];
  end

endmodule

[rtl/gha_slot_eval.sv]
// ============================================================================
// Slot evaluation unit
// Classifies one slot id and forms the ids that every operation may store.
// ============================================================================
module gha_slot_eval (
  input  logic [gha_pkg::ID_W-1:0]  slot_id_i,
  input  logic [gha_pkg::IDX_W-1:0] slot_idx_i,
  input  logic [gha_pkg::ID_W-1:0]  handle_i,
  output gha_pkg::gha_eval_t        eval_o
);

  logic [gha_pkg::IDX_W-1:0] cur_idx;

  assign cur_idx = slot_id_i[gha_pkg::IDX_W-1:0];

  always_comb begin
    eval_o.is_free   = (cur_idx == '0);
    eval_o.is_marked = (cur_idx != '0) && (cur_idx != slot_idx_i);
    eval_o.id_match  = (slot_id_i == handle_i);
    // CAPACITY plus an index below CAPACITY is just the index with the next bit set.
    eval_o.stamped   = slot_id_i + gha_pkg::ID_W'({1'b1, slot_idx_i});
    eval_o.former    = {slot_id_i[gha_pkg::ID_W-1:gha_pkg::IDX_W], slot_idx_i};
    eval_o.cleared   = {slot_id_i[gha_pkg::ID_W-1:gha_pkg::IDX_W], {gha_pkg::IDX_W{1'b0}}};
    eval_o.released  = {handle_i[gha_pkg::ID_W-1:2], 1'b1, ~handle_i[0]};
  end

endmodule

[rtl/generational_handle_allocator_core.sv]
// ============================================================================
// Generational handle allocator
// Slot table of generational handles with acquire, release, reclaim, lookup.
// ============================================================================
// One request is handled at a time; the slot table has a single read port and
// a small sequencer walks it one slot per cycle through a shared evaluation
// unit, pausing while a ready result waits for the output register to be taken.
// Acquire checks one slot after another until it finds a free one, or until
// the table is full or every slot is taken. Reclaim walks the used slots twice,
// once to count the marked slots and once to free and report them. A new
// request is taken while the last result of the previous one waits in the
// output register. Slots at or above the high-water mark read as zero, so no
// clearing pass runs after reset.
module generational_handle_allocator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  gha_req_if.sink   req_i,
  gha_rsp_if.source rsp_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ACQ   = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_CNT   = 5'b01000,
    ST_RCL   = 5'b10000
  } gha_state_e;

  gha_state_e state_q, state_d;

  logic [gha_pkg::SLOT_W-1:0] scan_q, scan_d;
  logic [gha_pkg::SLOT_W-1:0] used_q, used_d;
  logic [gha_pkg::SLOT_W-1:0] live_q, live_d;
  logic [gha_pkg::SLOT_W-1:0] count_q, count_d;

  gha_pkg::gha_op_e           op_q, op_d;
  logic [gha_pkg::ID_W-1:0]   id_q, id_d;
  logic [gha_pkg::KIND_W-1:0] kind_q, kind_d;

  gha_pkg::gha_rsp_t rsp_q, rsp_d;
  logic              out_valid_q, out_valid_d;
  logic              emit;
  logic              can_emit;

  gha_pkg::gha_wr_t           wr;
  logic [gha_pkg::ID_W-1:0]   rd_id;
  logic [gha_pkg::KIND_W-1:0] rd_kind;
  logic                       rd_valid;
  logic [gha_pkg::ID_W-1:0]   slot_id;
  gha_pkg::gha_eval_t         ev;
  logic                       check_ok;

  gha_slot_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (scan_d[gha_pkg::IDX_W-1:0]),
    .wr_i      (wr),
    .rd_id_o   (rd_id),
    .rd_kind_o (rd_kind)
  );

  // The read address is the next scan position, so the data for scan_q is
  // always waiting in the read register.
  assign rd_valid = (scan_q != '0) && (scan_q < used_q);
  assign slot_id  = rd_valid ? rd_id : '0;

  gha_slot_eval u_eval (
    .slot_id_i  (slot_id),
    .slot_idx_i (scan_q[gha_pkg::IDX_W-1:0]),
    .handle_i   (id_q),
    .eval_o     (ev)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign can_emit    = !out_valid_q || rsp_o.ready;
  assign check_ok    = rd_valid && ev.id_match;

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    used_d  = used_q;
    live_d  = live_q;
    count_d = count_q;
    op_d    = op_q;
    id_d    = id_q;
    kind_d  = kind_q;
    rsp_d   = rsp_q;
    emit    = 1'b0;
    wr      = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d   = gha_pkg::gha_op_e'(req_i.operation);
          id_d   = req_i.entity_id;
          kind_d = req_i.kind_tag;
          case (gha_pkg::gha_op_e'(req_i.operation))
            gha_pkg::OP_ACQUIRE: begin
              scan_d  = gha_pkg::SLOT_W'(1);
              state_d = ST_ACQ;
            end
            gha_pkg::OP_RECLAIM: begin
              scan_d  = gha_pkg::SLOT_W'(1);
              count_d = '0;
              state_d = ST_CNT;
            end
            default: begin
              scan_d  = gha_pkg::SLOT_W'(req_i.entity_id[gha_pkg::IDX_W-1:0]);
              state_d = ST_CHECK;
            end
          endcase
        end
      end

      ST_ACQ: begin
        if (live_q >= gha_pkg::SLOT_W'(gha_pkg::CAPACITY - 1) ||
            scan_q == gha_pkg::SLOT_W'(gha_pkg::CAPACITY)) begin
          // Table full, or every slot is live or awaiting reclaim.
          if (can_emit) begin
            emit       = 1'b1;
            rsp_d      = '0;
            rsp_d.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (ev.is_free) begin
          if (can_emit) begin
            wr.id_we   = 1'b1;
            wr.kind_we = 1'b1;
            wr.addr    = scan_q[gha_pkg::IDX_W-1:0];
            wr.id      = ev.stamped;
            wr.kind    = kind_q;
            if (scan_q >= used_q) begin
              used_d = scan_q + gha_pkg::SLOT_W'(1);
            end
            live_d           = live_q + gha_pkg::SLOT_W'(1);
            emit             = 1'b1;
            rsp_d            = '0;
            rsp_d.handle_out = ev.stamped;
            rsp_d.success    = 1'b1;
            rsp_d.last       = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          scan_d = scan_q + gha_pkg::SLOT_W'(1);
        end
      end

      ST_CHECK: begin
        if (can_emit) begin
          if (check_ok && op_q == gha_pkg::OP_RELEASE) begin
            wr.id_we = 1'b1;
            wr.addr  = scan_q[gha_pkg::IDX_W-1:0];
            wr.id    = ev.released;
          end
          emit          = 1'b1;
          rsp_d         = '0;
          rsp_d.success = check_ok;
          if (check_ok && op_q == gha_pkg::OP_LOOKUP) begin
            rsp_d.kind_out = rd_kind;
          end
          rsp_d.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_CNT: begin
        // First pass: every reclaim result carries the final count, so count first.
        if (scan_q < used_q) begin
          if (ev.is_marked) begin
            count_d = count_q + gha_pkg::SLOT_W'(1);
          end
          scan_d = scan_q + gha_pkg::SLOT_W'(1);
        end else begin
          live_d  = (live_q > count_q) ? live_q - count_q : '0;
          scan_d  = gha_pkg::SLOT_W'(1);
          state_d = ST_RCL;
        end
      end

      ST_RCL: begin
        if (scan_q < used_q) begin
          if (ev.is_marked) begin
            if (can_emit) begin
              wr.id_we         = 1'b1;
              wr.addr          = scan_q[gha_pkg::IDX_W-1:0];
              wr.id            = ev.cleared;
              emit             = 1'b1;
              rsp_d            = '0;
              rsp_d.handle_out = ev.former;
              rsp_d.success    = 1'b1;
              scan_d           = scan_q + gha_pkg::SLOT_W'(1);
            end
          end else begin
            scan_d = scan_q + gha_pkg::SLOT_W'(1);
          end
        end else if (can_emit) begin
          emit          = 1'b1;
          rsp_d         = '0;
          rsp_d.success = 1'b1;
          rsp_d.last    = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      rsp_d.reclaimed_count = (op_q == gha_pkg::OP_RECLAIM) ? gha_pkg::CNT_W'(count_q) : '0;
      rsp_d.active_count    = gha_pkg::CNT_W'(live_d);
      rsp_d.high_water      = gha_pkg::CNT_W'(used_d);
    end
  end

  assign out_valid_d = emit || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      used_q      <= '0;
      live_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      used_q      <= used_d;
      live_q      <= live_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    id_q   <= id_d;
    kind_q <= kind_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.handle_out      = rsp_q.handle_out;
  assign rsp_o.kind_out        = rsp_q.kind_out;
  assign rsp_o.success         = rsp_q.success;
  assign rsp_o.reclaimed_count = rsp_q.reclaimed_count;
  assign rsp_o.active_count    = rsp_q.active_count;
  assign rsp_o.high_water      = rsp_q.high_water;
  assign rsp_o.last            = rsp_q.last;

endmodule

[tb/tb_top.sv]
// ============================================================================
// Generational handle allocator testbench
// Sends acquire, release, reclaim and lookup requests under random handshake
// gaps. It predicts every response from its own copy of the slot table and
// compares each response field by field, in order.
// ============================================================================
module tb_top;
  import gha_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned MAX_REPORTS = 100;

  logic clk_i = 1'b0;
  logic rst_ni;

  gha_req_if req_ch ();
  gha_rsp_if rsp_ch ();

  generational_handle_allocator_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Expected slot table, mirrored request by request.
  logic [ID_W-1:0]   slot_id_tbl   [CAPACITY];
  logic [KIND_W-1:0] slot_kind_tbl [CAPACITY];
  int unsigned       used_cnt;
  int unsigned       live_cnt;

  gha_rsp_t    slot_results_due [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          idle_off;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ID_W-1:0] compose_id(input logic [ID_W-IDX_W-1:0] gen,
                                                 input logic [IDX_W-1:0] idx);
    return {gen, idx};
  endfunction

  function automatic bit id_is_live(input logic [ID_W-1:0] id);
    logic [IDX_W-1:0] idx;
    idx = id[IDX_W-1:0];
    return idx != '0 && idx < used_cnt && slot_id_tbl[idx] == id;
  endfunction

  // Handle for a release or lookup: mostly live ones, then handles of used
  // slots in their current generation (live, marked or already reclaimed),
  // older generations, index-zero handles, unused slots and plain noise.
  function automatic logic [ID_W-1:0] pick_target_id();
    logic [ID_W-1:0] pick;
    int unsigned     sel, start, s, n, found;
    pick  = $urandom();
    sel   = $urandom_range(0, 99);
    found = 0;
    if (used_cnt > 1) begin
      start = $urandom_range(1, CAPACITY - 1);
      for (n = 0; n < CAPACITY - 1; n++) begin
        s = 1 + (start - 1 + n) % (CAPACITY - 1);
        if (found == 0 && s < used_cnt && (sel >= 55 || slot_id_tbl[s][IDX_W-1:0] == s))
          found = s;
      end
    end
    if (sel < 55 && found != 0) return slot_id_tbl[found];
    if (sel >= 55 && sel < 65 && found != 0)
      return compose_id(slot_id_tbl[found][ID_W-1:IDX_W], IDX_W'(found));
    if (sel >= 65 && sel < 70 && found != 0)
      return compose_id(slot_id_tbl[found][ID_W-1:IDX_W] - 1'b1, IDX_W'(found));
    if (sel >= 70 && sel < 80) return compose_id(pick[ID_W-1:IDX_W], '0);
    if (sel >= 80 && sel < 90 && used_cnt < CAPACITY)
      return compose_id(pick[ID_W-1:IDX_W],
                        IDX_W'($urandom_range(used_cnt, CAPACITY - 1)));
    return pick;
  endfunction

  // Applies one accepted request to the expected table and queues the
  // responses it must produce.
  task automatic step_slot_table(input gha_op_e op, input logic [ID_W-1:0] id,
                                 input logic [KIND_W-1:0] kind);
    gha_rsp_t        r;
    gha_rsp_t        batch [$];
    logic [ID_W-1:0] cur;
    int unsigned     idx, i, k, freed;
    r     = '0;
    freed = 0;
    case (op)
      OP_ACQUIRE: begin
        idx = CAPACITY;
        if (live_cnt + 1 < CAPACITY) begin
          for (i = 1; i < CAPACITY; i++) begin
            if (idx == CAPACITY && (i >= used_cnt || slot_id_tbl[i][IDX_W-1:0] == '0))
              idx = i;
          end
        end
        if (idx < CAPACITY) begin
          if (idx >= used_cnt) used_cnt = idx + 1;
          slot_kind_tbl[idx] = kind;
          slot_id_tbl[idx]   = slot_id_tbl[idx] + CAPACITY + idx;
          live_cnt++;
          r.handle_out = slot_id_tbl[idx];
          r.success    = 1'b1;
        end
        batch.push_back(r);
      end
      OP_RELEASE: begin
        if (id_is_live(id)) begin
          slot_id_tbl[id[IDX_W-1:0]] = (id ^ 32'd1) | 32'd2;
          r.success = 1'b1;
        end
        batch.push_back(r);
      end
      OP_RECLAIM: begin
        for (i = 1; i < used_cnt && i < CAPACITY; i++) begin
          cur = slot_id_tbl[i];
          if (cur[IDX_W-1:0] != i && cur[IDX_W-1:0] != '0) begin
            r            = '0;
            r.handle_out = compose_id(cur[ID_W-1:IDX_W], IDX_W'(i));
            r.success    = 1'b1;
            batch.push_back(r);
            slot_id_tbl[i] = compose_id(cur[ID_W-1:IDX_W], '0);
            if (live_cnt > 0) live_cnt--;
            freed++;
          end
        end
        r         = '0;
        r.success = 1'b1;
        batch.push_back(r);
      end
      default: begin
        if (id_is_live(id)) begin
          r.kind_out = slot_kind_tbl[id[IDX_W-1:0]];
          r.success  = 1'b1;
        end
        batch.push_back(r);
      end
    endcase
    for (k = 0; k < batch.size(); k++) begin
      r                 = batch[k];
      r.reclaimed_count = freed[CNT_W-1:0];
      r.active_count    = live_cnt[CNT_W-1:0];
      r.high_water      = used_cnt[CNT_W-1:0];
      r.last            = (k == batch.size() - 1);
      slot_results_due.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("cycle %0d: %s mismatch, got %h, expected %h", cycle_count, field, got,
               want);
  endtask

  // Response checker.
  always @(posedge clk_i) begin : check_rsp
    gha_rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (slot_results_due.size() == 0) begin
        report_mismatch("unexpected response, handle_out", rsp_ch.handle_out, '0);
      end else begin
        want = slot_results_due.pop_front();
        if (rsp_ch.handle_out !== want.handle_out)
          report_mismatch("handle_out", rsp_ch.handle_out, want.handle_out);
        if (rsp_ch.kind_out !== want.kind_out)
          report_mismatch("kind_out", rsp_ch.kind_out, want.kind_out);
        if (rsp_ch.success !== want.success)
          report_mismatch("success", 32'(rsp_ch.success), 32'(want.success));
        if (rsp_ch.reclaimed_count !== want.reclaimed_count)
          report_mismatch("reclaimed_count", 32'(rsp_ch.reclaimed_count),
                          32'(want.reclaimed_count));
        if (rsp_ch.active_count !== want.active_count)
          report_mismatch("active_count", 32'(rsp_ch.active_count),
                          32'(want.active_count));
        if (rsp_ch.high_water !== want.high_water)
          report_mismatch("high_water", 32'(rsp_ch.high_water), 32'(want.high_water));
        if (rsp_ch.last !== want.last)
          report_mismatch("last", 32'(rsp_ch.last), 32'(want.last));
      end
    end
  end

  // Response back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0 && !idle_off) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall_left = 0;
      if (!idle_off && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Valid stays high between back-to-back requests, so it is only lowered
  // when a gap actually follows.
  task automatic send_request(input gha_op_e op, input logic [ID_W-1:0] id,
                              input logic [KIND_W-1:0] kind);
    int unsigned gap;
    gap = 0;
    if (!idle_off && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.entity_id <= id;
    req_ch.kind_tag  <= kind;
    do @(posedge clk_i); while (!req_ch.ready);
    step_slot_table(op, id, kind);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (slot_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, '1, '1);
    send_request(OP_RELEASE, $urandom(), $urandom());
    send_request(OP_RECLAIM, $urandom(), $urandom());
    send_request(OP_RELEASE, '1, '0);
  endtask

  task automatic test_acquire_basics();
    logic [ID_W-1:0] h;
    int unsigned     s;
    send_request(OP_ACQUIRE, '0, '0);
    send_request(OP_ACQUIRE, '1, '1);
    send_request(OP_ACQUIRE, $urandom(), $urandom());
    for (s = 1; s <= 3; s++) send_request(OP_LOOKUP, slot_id_tbl[s], '0);
    // A plausible generation, but a slot above the high-water mark.
    send_request(OP_LOOKUP, compose_id(slot_id_tbl[1][ID_W-1:IDX_W], IDX_W'(5)), '0);
    h = slot_id_tbl[2];
    send_request(OP_RELEASE, h, $urandom());
    send_request(OP_LOOKUP, h, '0);
    send_request(OP_RELEASE, h, '0);
    send_request(OP_RECLAIM, '0, '0);
    send_request(OP_LOOKUP, h, '0);
    send_request(OP_ACQUIRE, '0, 32'h1234_5678);
    send_request(OP_RELEASE, h, '0);
    send_request(OP_LOOKUP, slot_id_tbl[2], '0);
    send_request(OP_RELEASE, compose_id(slot_id_tbl[1][ID_W-1:IDX_W], '0), '0);
    send_request(OP_LOOKUP, compose_id('1, '0), '1);
  endtask

  // Fills the table until acquire is refused, marks every live handle and
  // reclaims them all in one pass.
  task automatic test_fill_until_full();
    int unsigned start, s, n;
    while (live_cnt + 1 < CAPACITY) send_request(OP_ACQUIRE, $urandom(), $urandom());
    repeat (3) send_request(OP_ACQUIRE, $urandom(), $urandom());
    repeat (6) send_request(OP_LOOKUP, pick_target_id(), $urandom());
    start = $urandom_range(1, CAPACITY - 1);
    for (n = 0; n < CAPACITY - 1; n++) begin
      s = 1 + (start - 1 + n) % (CAPACITY - 1);
      if (s < used_cnt && slot_id_tbl[s][IDX_W-1:0] == s)
        send_request(OP_RELEASE, slot_id_tbl[s], $urandom());
    end
    // Marked slots still hold their place until they are reclaimed.
    send_request(OP_ACQUIRE, $urandom(), $urandom());
    send_request(OP_RECLAIM, $urandom(), $urandom());
    drain_results();
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned sel, acq;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      acq = (live_cnt > 24) ? 20 : 40;
      if (sel < acq) send_request(OP_ACQUIRE, $urandom(), $urandom());
      else if (sel < acq + 30) send_request(OP_RELEASE, pick_target_id(), $urandom());
      else if (sel < 88) send_request(OP_LOOKUP, pick_target_id(), $urandom());
      else send_request(OP_RECLAIM, $urandom(), $urandom());
    end
  endtask

  initial begin
    int unsigned s;
    for (s = 0; s < CAPACITY; s++) begin
      slot_id_tbl[s]   = '0;
      slot_kind_tbl[s] = '0;
    end
    used_cnt    = 0;
    live_cnt    = 0;
    idle_off    = 1'b0;
    rst_ni           <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_ACQUIRE;
    req_ch.entity_id <= '0;
    req_ch.kind_tag  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_acquire_basics();
    test_fill_until_full();
    test_random_mix(140);
    drain_results();
    idle_off = 1'b1;
    test_random_mix(80);
    idle_off = 1'b0;
    test_random_mix(150);

    drain_results();
    repeat (2 * CAPACITY + 16) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/gha_pkg.sv
rtl/gha_if.sv
rtl/gha_slot_store.sv
rtl/gha_slot_eval.sv
rtl/generational_handle_allocator_core.sv
tb/tb_top.sv
